[src/baseline_rule_list_match_unit_macros.svh]
// Assertion macros used by the checker file.
`ifndef BASELINE_RULE_LIST_MATCH_UNIT_MACROS_SVH
`define BASELINE_RULE_LIST_MATCH_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define BLRM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define BLRM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/blrm_pkg.sv]
// Shared types, codes and the rule match function of the baseline rule list unit.
package blrm_pkg;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] LVL_ALL      = 2'd0;
	localparam logic [1:0] LVL_SUBARRAY = 2'd1;
	localparam logic [1:0] LVL_STATION  = 2'd2;
	localparam logic [1:0] LVL_PAIR     = 2'd3;

	typedef struct packed {
		logic [1:0] level;
		logic       incl;
		logic [3:0] sub;
		logic [7:0] sta;
		logic [7:0] stb;
	} rule_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
	} cmd_t;

	typedef struct packed {
		logic query_in;
		logic skip;
		logic last;
	} stat_t;

	function automatic logic rule_cites(rule_t r, logic [3:0] sub, logic [7:0] a,
			logic [7:0] b);
		logic hit;
		case (r.level)
			LVL_ALL:      hit = 1'b1;
			LVL_SUBARRAY: hit = (r.sub == sub);
			LVL_STATION:  hit = (r.sub == sub) && ((r.sta == a) || (r.sta == b));
			LVL_PAIR:     hit = (r.sub == sub) &&
				(((r.sta == a) && (r.stb == b)) || ((r.sta == b) && (r.stb == a)));
			default:      hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

[src/blrm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module blrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/blrm_ctrl.sv]
// Controller state machine: sequences accept, rule scan and result beat.
module blrm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  blrm_pkg::stat_t     st,
	output blrm_pkg::cmd_t      cmd,
	output logic                busy,
	output logic                done
);

	blrm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blrm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.scan = 1'b0;
		busy     = 1'b1;
		done     = 1'b0;
		case (state_q)
			blrm_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = st.query_in ? blrm_pkg::ST_SCAN : blrm_pkg::ST_FINISH;
				end
			end
			blrm_pkg::ST_SCAN: begin
				if (st.skip) begin
					state_d = blrm_pkg::ST_FINISH;
				end else begin
					cmd.scan = 1'b1;
					if (st.last) begin
						state_d = blrm_pkg::ST_DRAIN;
					end
				end
			end
			// last read word is being evaluated
			blrm_pkg::ST_DRAIN: begin
				state_d = blrm_pkg::ST_FINISH;
			end
			blrm_pkg::ST_FINISH: begin
				done    = 1'b1;
				state_d = blrm_pkg::ST_IDLE;
			end
			default: begin
				state_d = blrm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[src/blrm_dp.sv]
// Datapath: rule memory, rule count, scan index and last-match register.
module blrm_dp #(
	parameter int MAX_RULES     = 16,
	parameter int MAX_STATIONS  = 256,
	parameter int MAX_SUBARRAYS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  blrm_pkg::cmd_t   cmd,
	output blrm_pkg::stat_t  st,
	input  logic [1:0]       operation,
	input  logic [1:0]       rule_level,
	input  logic             rule_include,
	input  logic [3:0]       subarray,
	input  logic [7:0]       station_a,
	input  logic [7:0]       station_b,
	output logic             included,
	output logic             status,
	output logic [4:0]       rule_count
);

	localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int CW = $clog2(MAX_RULES + 1);
	localparam int EW = $bits(blrm_pkg::rule_t);

	logic [CW-1:0]   held_q;
	logic [AW-1:0]   idx_q;
	logic            skip_q;
	logic            match_q;
	logic            status_q;
	logic            rd_valid_s1;
	logic [3:0]      sub_q;
	logic [7:0]      sta_q;
	logic [7:0]      stb_q;

	logic            full;
	logic            wr_en;
	logic            out_of_range;
	blrm_pkg::rule_t wr_entry;
	blrm_pkg::rule_t rd_entry;
	logic [EW-1:0]   rd_word;
	logic [31:0]     held_ext;

	assign full = (held_q >= CW'(MAX_RULES));
	assign wr_en = cmd.load && (operation == blrm_pkg::OP_APPEND) && !full;
	assign out_of_range = (32'(subarray) >= 32'(MAX_SUBARRAYS)) ||
		(32'(station_a) >= 32'(MAX_STATIONS)) ||
		(32'(station_b) >= 32'(MAX_STATIONS));

	always_comb begin
		wr_entry.level = rule_level;
		wr_entry.incl  = rule_include;
		wr_entry.sub   = subarray;
		wr_entry.sta   = station_a;
		wr_entry.stb   = station_b;
	end

	blrm_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_RULES)
	) u_rules (
		.clk   (clk),
		.we    (wr_en),
		.waddr (held_q[AW-1:0]),
		.wdata (wr_entry),
		.re    (cmd.scan),
		.raddr (idx_q),
		.rdata (rd_word)
	);

	assign rd_entry = blrm_pkg::rule_t'(rd_word);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			idx_q       <= '0;
			skip_q      <= 1'b1;
			rd_valid_s1 <= 1'b0;
			match_q     <= 1'b0;
			status_q    <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan;
			if (cmd.load) begin
				idx_q    <= '0;
				match_q  <= 1'b0;
				status_q <= 1'b0;
				skip_q   <= out_of_range || (held_q == '0);
				case (operation)
					blrm_pkg::OP_CLEAR: begin
						held_q <= '0;
					end
					blrm_pkg::OP_APPEND: begin
						if (full) begin
							status_q <= 1'b1;
						end else begin
							held_q <= held_q + CW'(1);
						end
					end
					default: begin
					end
				endcase
			end else begin
				if (cmd.scan) begin
					idx_q <= idx_q + AW'(1);
				end
				// newest matching rule wins
				if (rd_valid_s1 && blrm_pkg::rule_cites(rd_entry, sub_q, sta_q, stb_q)) begin
					match_q <= rd_entry.incl;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sub_q <= subarray;
			sta_q <= station_a;
			stb_q <= station_b;
		end
	end

	assign st.query_in = (operation == blrm_pkg::OP_QUERY);
	assign st.skip     = skip_q;
	assign st.last     = ((CW'(idx_q) + CW'(1)) == held_q);

	assign held_ext   = 32'(held_q);
	assign included   = match_q;
	assign status     = status_q;
	assign rule_count = held_ext[4:0];

endmodule

[src/baseline_rule_list_match_unit.sv]
// Baseline rule list match unit: top level joining controller and datapath.
//
// One item is taken when start is high and busy is low; its single result
// beat shows on included, status and rule_count for exactly one cycle with
// done high, and must be taken then since there is no way to hold it off.
// Clear, append and the unused operation code go from accept straight to the
// result beat. A query passes through the scan and drain states, since the
// rule memory has one read port and is scanned one rule per cycle, oldest
// first, keeping the last rule that matches; it skips the scan when the list
// is empty or the subarray or a station is out of range. busy stays high
// until the result beat has gone out. No clearing pass is needed after reset.
module baseline_rule_list_match_unit #(
	parameter int MAX_RULES     = 16,
	parameter int MAX_STATIONS  = 256,
	parameter int MAX_SUBARRAYS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] operation,
	input  logic [1:0] rule_level,
	input  logic       rule_include,
	input  logic [3:0] subarray,
	input  logic [7:0] station_a,
	input  logic [7:0] station_b,
	output logic       done,
	output logic       included,
	output logic       status,
	output logic [4:0] rule_count
);

	blrm_pkg::cmd_t  cmd;
	blrm_pkg::stat_t st;

	blrm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	blrm_dp #(
		.MAX_RULES     (MAX_RULES),
		.MAX_STATIONS  (MAX_STATIONS),
		.MAX_SUBARRAYS (MAX_SUBARRAYS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.operation    (operation),
		.rule_level   (rule_level),
		.rule_include (rule_include),
		.subarray     (subarray),
		.station_a    (station_a),
		.station_b    (station_b),
		.included     (included),
		.status       (status),
		.rule_count   (rule_count)
	);

endmodule

[src/blrm_checker.sv]
// Port-level checker for the baseline rule list match unit, with its bind.
`include "baseline_rule_list_match_unit_macros.svh"

module blrm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] operation,
	input logic [1:0] rule_level,
	input logic       rule_include,
	input logic [3:0] subarray,
	input logic [7:0] station_a,
	input logic [7:0] station_b,
	input logic       done,
	input logic       included,
	input logic       status,
	input logic [4:0] rule_count
);

	`BLRM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "no busy after accept")
	`BLRM_ASSERT_NOW(a_done_in_busy, done, busy, "result beat while idle")
	`BLRM_ASSERT_NEXT(a_done_single, done, !done, "result beat longer than one cycle")
	`BLRM_ASSERT_NOW(a_excl_flags, done, !(included && status), "included on refused append")

endmodule

bind baseline_rule_list_match_unit blrm_checker u_blrm_checker (.*);
